// ===== design/three_point_inverse_interpolation_macros.svh =====
// Assertion helpers for the block's top-level RTL file.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef THREE_POINT_INVERSE_INTERPOLATION_MACROS_SVH
`define THREE_POINT_INVERSE_INTERPOLATION_MACROS_SVH

// Checked only while out of reset.
`define TPII_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TPII_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tpii_pkg.sv =====
// ----------------------------------------------------------------------------
// tpii_pkg
// Types and fixed-point constants of the three-point inverse interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpii_pkg;

  localparam int QF        = 16;  // fraction bits of Q16.16
  localparam int XW        = 32;  // input and result words
  localparam int UW        = 33;  // first differences, x span
  localparam int CW        = 34;  // second difference, a+b, 2*u1
  localparam int NW        = 25;  // offset n, held within +-255.0
  localparam int TW        = 39;  // t1, t2 after saturation
  localparam int OPW       = 39;  // wide multiplier operand
  localparam int MAC_SPLIT = 20;  // low slice of the wide operand
  localparam int PW        = 64;  // full product
  localparam int NUMW      = 49;  // numerator
  localparam int DENW      = 40;  // denominator
  localparam int QW        = 17;  // quotient magnitude, up to 1.0
  localparam int DW        = 18;  // signed step
  localparam int ITW       = 8;   // iteration count
  localparam int TOLW      = 17;  // tolerance register
  localparam int DIV_STEPS = 16;  // quotient bits below the binary point
  localparam int CNTW      = 5;   // holds DIV_STEPS

  localparam logic [QW-1:0]          ONE_Q16   = 17'd65536;
  localparam logic [TOLW-1:0]        TOL_RESET = 17'd66;
  localparam logic signed [NW-1:0]   N_LIMIT   = 25'sd16711680;
  localparam logic signed [TW-1:0]   T_LIMIT   = 39'sh3F_FFFF_FFFF;
  localparam logic signed [XW-1:0]   X_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [XW-1:0]   X_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    STATUS_CONVERGED  = 2'd0,
    STATUS_ITER_LIMIT = 2'd1,
    STATUS_ZERO_DEN   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_CHK,
    ST_T1_WAIT,
    ST_T2,
    ST_NUM_MUL,
    ST_NUM_WAIT,
    ST_DEN,
    ST_DIV_WAIT,
    ST_UPD,
    ST_XMUL,
    ST_X_WAIT,
    ST_XOUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic signed [NW-1:0]  n;
    logic signed [OPW-1:0] op;
  } mac_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] prod;
  } mac_rsp_t;

  typedef struct packed {
    logic            start;
    logic [NUMW-1:0] un;
    logic [DENW-1:0] ud;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] q;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/three_point_inverse_interpolation.sv =====
// Three-point inverse interpolator. A word passes through the setup states
// PREP1 and PREP2, then at most MAX_ITERATIONS Newton steps (a multiply for
// c*n, another for n*t2, and a restoring division), and then a last multiply
// that forms x_result before it is handed over. The serial divider and the
// single shared multiplier set how long a word takes. in_ready is high only
// while the sequencer is idle; a finished result waits in the output register
// and does not block the next word. The tolerance register may be written at
// any cycle while idle.
`default_nettype none

`include "three_point_inverse_interpolation_macros.svh"

module three_point_inverse_interpolation #(
  parameter int MAX_ITERATIONS = 30
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tpii_pkg::TOLW-1:0]     cfg_tolerance,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [tpii_pkg::XW-1:0] in_x_first,
  input  wire logic signed [tpii_pkg::XW-1:0] in_x_middle,
  input  wire logic signed [tpii_pkg::XW-1:0] in_y_first,
  input  wire logic signed [tpii_pkg::XW-1:0] in_y_middle,
  input  wire logic signed [tpii_pkg::XW-1:0] in_y_last,
  input  wire logic signed [tpii_pkg::XW-1:0] in_target_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [tpii_pkg::XW-1:0]     out_x_result,
  output logic [1:0]                         out_status,
  output logic [tpii_pkg::ITW-1:0]           out_iterations_used
);

  localparam int PW = tpii_pkg::PW;

  tpii_pkg::state_t  state_r, state_nxt;
  tpii_pkg::status_t stat_r, stat_nxt;
  tpii_pkg::status_t out_stat_r, out_stat_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [tpii_pkg::TOLW-1:0]         tol_r, tol_nxt;
  logic [tpii_pkg::ITW-1:0]          iter_r, iter_nxt;
  logic signed [tpii_pkg::NW-1:0]    n_r, n_nxt;

  logic signed [tpii_pkg::XW-1:0]    x0_r, x0_nxt, x1_r, x1_nxt;
  logic signed [tpii_pkg::XW-1:0]    y0_r, y0_nxt, y1_r, y1_nxt, y2_r, y2_nxt;
  logic signed [tpii_pkg::XW-1:0]    ty_r, ty_nxt;
  logic signed [tpii_pkg::UW-1:0]    a_r, a_nxt, b_r, b_nxt, dx_r, dx_nxt;
  logic signed [tpii_pkg::CW-1:0]    c_r, c_nxt, s_r, s_nxt, dy_r, dy_nxt;
  logic signed [tpii_pkg::TW-1:0]    t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [tpii_pkg::NUMW-1:0]  num_r, num_nxt;
  logic signed [tpii_pkg::DENW-1:0]  den_r, den_nxt;
  logic signed [tpii_pkg::XW-1:0]    out_x_r, out_x_nxt;
  logic [tpii_pkg::ITW-1:0]          out_iter_r, out_iter_nxt;

  tpii_pkg::mac_req_t mac_req;
  tpii_pkg::mac_rsp_t mac_rsp;
  tpii_pkg::div_req_t div_req;
  tpii_pkg::div_rsp_t div_rsp;

  logic                              at_limit;
  logic                              den_zero;
  logic                              step_neg;
  logic signed [tpii_pkg::DW-1:0]    q_s;
  logic signed [tpii_pkg::DW-1:0]    step;
  logic signed [tpii_pkg::NW:0]      n_sum;
  logic signed [tpii_pkg::NW-1:0]    n_upd;
  logic signed [PW-1:0]              prod_q;
  logic signed [PW-1:0]              x_sum;
  logic signed [tpii_pkg::XW-1:0]    x_sat;
  logic                              converged;
  logic                              out_load;

  function automatic logic signed [tpii_pkg::TW-1:0] clamp_t(input logic signed [PW-1:0] v);
    logic signed [tpii_pkg::TW-1:0] r;
    if (v > PW'(tpii_pkg::T_LIMIT)) r = tpii_pkg::T_LIMIT;
    else if (v < -PW'(tpii_pkg::T_LIMIT)) r = -tpii_pkg::T_LIMIT;
    else r = tpii_pkg::TW'(v);
    return r;
  endfunction

  tpii_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

  tpii_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Shared arithmetic around the sequencer.
  always_comb begin
    at_limit  = iter_r == tpii_pkg::ITW'(MAX_ITERATIONS);
    den_zero  = den_r == '0;
    // The step is -(num/den), so it is negative when both have the same sign.
    step_neg  = num_r[tpii_pkg::NUMW-1] == den_r[tpii_pkg::DENW-1];
    q_s       = $signed({1'b0, div_rsp.q});
    step      = step_neg ? -q_s : q_s;
    n_sum     = (tpii_pkg::NW + 1)'(n_r) + (tpii_pkg::NW + 1)'(step);
    if (n_sum > (tpii_pkg::NW + 1)'(tpii_pkg::N_LIMIT)) n_upd = tpii_pkg::N_LIMIT;
    else if (n_sum < -(tpii_pkg::NW + 1)'(tpii_pkg::N_LIMIT)) n_upd = -tpii_pkg::N_LIMIT;
    else n_upd = tpii_pkg::NW'(n_sum);
    converged = tpii_pkg::TOLW'(div_rsp.q) < tol_r;
    prod_q    = mac_rsp.prod >>> tpii_pkg::QF;
    x_sum     = PW'(x1_r) + prod_q;
    if (x_sum > PW'(tpii_pkg::X_MAX)) x_sat = tpii_pkg::X_MAX;
    else if (x_sum < PW'(tpii_pkg::X_MIN)) x_sat = tpii_pkg::X_MIN;
    else x_sat = tpii_pkg::XW'(x_sum);
    out_load  = !out_valid_r || out_ready;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpii_pkg::ST_IDLE:     if (in_valid) state_nxt = tpii_pkg::ST_PREP1;
      tpii_pkg::ST_PREP1:    state_nxt = tpii_pkg::ST_PREP2;
      tpii_pkg::ST_PREP2:    state_nxt = tpii_pkg::ST_CHK;
      tpii_pkg::ST_CHK:      state_nxt = at_limit ? tpii_pkg::ST_XMUL : tpii_pkg::ST_T1_WAIT;
      tpii_pkg::ST_T1_WAIT:  if (mac_rsp.done) state_nxt = tpii_pkg::ST_T2;
      tpii_pkg::ST_T2:       state_nxt = tpii_pkg::ST_NUM_MUL;
      tpii_pkg::ST_NUM_MUL:  state_nxt = tpii_pkg::ST_NUM_WAIT;
      tpii_pkg::ST_NUM_WAIT: if (mac_rsp.done) state_nxt = tpii_pkg::ST_DEN;
      tpii_pkg::ST_DEN:      state_nxt = den_zero ? tpii_pkg::ST_XMUL : tpii_pkg::ST_DIV_WAIT;
      tpii_pkg::ST_DIV_WAIT: if (div_rsp.done) state_nxt = tpii_pkg::ST_UPD;
      tpii_pkg::ST_UPD:      state_nxt = converged ? tpii_pkg::ST_XMUL : tpii_pkg::ST_CHK;
      tpii_pkg::ST_XMUL:     state_nxt = tpii_pkg::ST_X_WAIT;
      tpii_pkg::ST_X_WAIT:   if (mac_rsp.done) state_nxt = tpii_pkg::ST_XOUT;
      tpii_pkg::ST_XOUT:     if (out_load) state_nxt = tpii_pkg::ST_IDLE;
      default:               state_nxt = tpii_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = 1'b0;
    mac_req.start = 1'b0;
    mac_req.n     = n_r;
    mac_req.op    = tpii_pkg::OPW'(dx_r);
    div_req.start = 1'b0;
    div_req.un    = num_r[tpii_pkg::NUMW-1] ? tpii_pkg::NUMW'(-num_r) : tpii_pkg::NUMW'(num_r);
    div_req.ud    = den_r[tpii_pkg::DENW-1] ? tpii_pkg::DENW'(-den_r) : tpii_pkg::DENW'(den_r);
    case (state_r)
      tpii_pkg::ST_IDLE: in_ready = 1'b1;
      tpii_pkg::ST_CHK: begin
        mac_req.start = !at_limit;
        mac_req.op    = tpii_pkg::OPW'(c_r);
      end
      tpii_pkg::ST_NUM_MUL: begin
        mac_req.start = 1'b1;
        mac_req.op    = tpii_pkg::OPW'(t2_r);
      end
      tpii_pkg::ST_DEN:  div_req.start = !den_zero;
      tpii_pkg::ST_XMUL: mac_req.start = 1'b1;
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    stat_nxt      = stat_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r;
    tol_nxt       = tol_r;
    iter_nxt      = iter_r;
    n_nxt         = n_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    y2_nxt        = y2_r;
    ty_nxt        = ty_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    dx_nxt        = dx_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    dy_nxt        = dy_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    out_x_nxt     = out_x_r;
    out_iter_nxt  = out_iter_r;

    if (cfg_valid) tol_nxt = cfg_tolerance;
    if (out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      tpii_pkg::ST_IDLE: begin
        if (in_valid) begin
          x0_nxt   = in_x_first;
          x1_nxt   = in_x_middle;
          y0_nxt   = in_y_first;
          y1_nxt   = in_y_middle;
          y2_nxt   = in_y_last;
          ty_nxt   = in_target_y;
          n_nxt    = '0;
          iter_nxt = '0;
        end
      end
      tpii_pkg::ST_PREP1: begin
        // The target cancels in the differences; it only enters 2*u1.
        a_nxt  = tpii_pkg::UW'(y1_r) - tpii_pkg::UW'(y0_r);
        b_nxt  = tpii_pkg::UW'(y2_r) - tpii_pkg::UW'(y1_r);
        dx_nxt = tpii_pkg::UW'(x1_r) - tpii_pkg::UW'(x0_r);
        dy_nxt = (tpii_pkg::CW'(y1_r) - tpii_pkg::CW'(ty_r)) <<< 1;
      end
      tpii_pkg::ST_PREP2: begin
        c_nxt = tpii_pkg::CW'(b_r) - tpii_pkg::CW'(a_r);
        s_nxt = tpii_pkg::CW'(a_r) + tpii_pkg::CW'(b_r);
      end
      tpii_pkg::ST_CHK: begin
        if (at_limit) stat_nxt = tpii_pkg::STATUS_ITER_LIMIT;
      end
      tpii_pkg::ST_T1_WAIT: begin
        if (mac_rsp.done) t1_nxt = clamp_t(prod_q);
      end
      tpii_pkg::ST_T2: begin
        t2_nxt = clamp_t(PW'(s_r) + PW'(t1_r));
      end
      tpii_pkg::ST_NUM_WAIT: begin
        if (mac_rsp.done) begin
          num_nxt = tpii_pkg::NUMW'(PW'(dy_r) + prod_q);
          den_nxt = tpii_pkg::DENW'(t1_r) + tpii_pkg::DENW'(t2_r);
        end
      end
      tpii_pkg::ST_DEN: begin
        if (den_zero) stat_nxt = tpii_pkg::STATUS_ZERO_DEN;
      end
      tpii_pkg::ST_UPD: begin
        n_nxt    = n_upd;
        iter_nxt = iter_r + tpii_pkg::ITW'(1);
        if (converged) stat_nxt = tpii_pkg::STATUS_CONVERGED;
      end
      tpii_pkg::ST_XOUT: begin
        if (out_load) begin
          out_x_nxt     = x_sat;
          out_stat_nxt  = stat_r;
          out_iter_nxt  = iter_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpii_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= tpii_pkg::TOL_RESET;
      iter_r      <= '0;
      n_r         <= '0;
      stat_r      <= tpii_pkg::STATUS_ITER_LIMIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tol_r       <= tol_nxt;
      iter_r      <= iter_nxt;
      n_r         <= n_nxt;
      stat_r      <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    y2_r       <= y2_nxt;
    ty_r       <= ty_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    dx_r       <= dx_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    dy_r       <= dy_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    out_x_r    <= out_x_nxt;
    out_stat_r <= out_stat_nxt;
    out_iter_r <= out_iter_nxt;
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_x_result        = out_x_r;
  assign out_status          = out_stat_r;
  assign out_iterations_used = out_iter_r;

  `TPII_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == tpii_pkg::ST_IDLE) && !out_valid, "reset did not idle the block")
  `TPII_ASSERT(a_iter_bound, iter_r <= tpii_pkg::ITW'(MAX_ITERATIONS), "step count beyond the limit")
  `TPII_ASSERT(a_n_bound, (n_r <= tpii_pkg::N_LIMIT) && (n_r >= -tpii_pkg::N_LIMIT), "offset n out of range")
  `TPII_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_r == tpii_pkg::ST_PREP1), "accepted word did not start")
  `TPII_ASSERT(a_limit_count, (out_valid && (out_status == tpii_pkg::STATUS_ITER_LIMIT)) |-> (out_iterations_used == tpii_pkg::ITW'(MAX_ITERATIONS)), "limit status with short count")

endmodule

`default_nettype wire

// ===== design/tpii_mac.sv =====
// ----------------------------------------------------------------------------
// tpii_mac
// Shared multiplier: n times a wide operand. The operands are registered at
// start, the two narrow partial products are then formed in turn and summed,
// and done rises together with the registered sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tpii_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tpii_pkg::mac_req_t req,
  output tpii_pkg::mac_rsp_t      rsp
);

  localparam int LOW = tpii_pkg::MAC_SPLIT;
  localparam int PLW = tpii_pkg::NW + LOW + 1;
  localparam int PHW = tpii_pkg::NW + tpii_pkg::OPW - LOW;

  logic [1:0]                            phase_r, phase_nxt;
  logic                                  done_r, done_nxt;
  logic signed [tpii_pkg::NW-1:0]        n_r;
  logic signed [tpii_pkg::OPW-1:0]       op_r;
  logic signed [PLW-1:0]                 pl_r;
  logic signed [PHW-1:0]                 ph_r;
  logic signed [tpii_pkg::PW-1:0]        prod_r;

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    case (phase_r)
      2'd0: if (req.start) phase_nxt = 2'd1;
      2'd1: phase_nxt = 2'd2;
      2'd2: phase_nxt = 2'd3;
      2'd3: begin
        phase_nxt = 2'd0;
        done_nxt  = 1'b1;
      end
      default: phase_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // The low slice is taken as unsigned, the high slice carries the sign.
  always_ff @(posedge clk) begin
    if (phase_r == 2'd0 && req.start) begin
      n_r  <= req.n;
      op_r <= req.op;
    end
    if (phase_r == 2'd1) pl_r <= n_r * $signed({1'b0, op_r[LOW-1:0]});
    if (phase_r == 2'd2) ph_r <= n_r * $signed(op_r[tpii_pkg::OPW-1:LOW]);
    if (phase_r == 2'd3) prod_r <= (tpii_pkg::PW'(ph_r) <<< LOW) + tpii_pkg::PW'(pl_r);
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule

`default_nettype wire

// ===== design/tpii_div.sv =====
// ----------------------------------------------------------------------------
// tpii_div
// Restoring divider for the Newton step: (un << 16) / ud, one quotient bit
// per cycle, or exactly 1.0 when un is not below ud.
// ----------------------------------------------------------------------------
`default_nettype none

module tpii_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tpii_pkg::div_req_t req,
  output tpii_pkg::div_rsp_t      rsp
);

  localparam int RW = tpii_pkg::DENW + 1;

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [tpii_pkg::CNTW-1:0]    cnt_r, cnt_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [tpii_pkg::DENW-1:0]    ud_r, ud_nxt;
  logic [tpii_pkg::QW-1:0]      q_r, q_nxt;
  logic [RW-1:0]                rem2;
  logic                         ge;
  logic                         big;

  always_comb begin
    rem2 = {rem_r[tpii_pkg::DENW-1:0], 1'b0};
    ge   = rem2 >= {1'b0, ud_r};
    big  = req.un >= tpii_pkg::NUMW'(req.ud);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    ud_nxt   = ud_r;
    q_nxt    = q_r;
    if (busy_r) begin
      rem_nxt = ge ? rem2 - {1'b0, ud_r} : rem2;
      q_nxt   = {q_r[tpii_pkg::QW-2:0], ge};
      cnt_nxt = cnt_r - tpii_pkg::CNTW'(1);
      if (cnt_r == tpii_pkg::CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      if (big) begin
        q_nxt    = tpii_pkg::ONE_Q16;
        done_nxt = 1'b1;
      end else begin
        // Here un < ud, so it fits the remainder.
        rem_nxt  = RW'(req.un[tpii_pkg::DENW-1:0]);
        ud_nxt   = req.ud;
        q_nxt    = '0;
        cnt_nxt  = tpii_pkg::CNTW'(tpii_pkg::DIV_STEPS);
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    ud_r  <= ud_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

`default_nettype wire

// ===== test/tb_three_point_inverse_interpolation.sv =====
// ----------------------------------------------------------------------------
// tb_three_point_inverse_interpolation
// Self-checking bench for the three-point inverse interpolator. A short table
// of directed words runs first, then random words under several tolerance
// settings; every result word is checked against the row's given answer or an in-bench Newton solver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_three_point_inverse_interpolation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_STEPS = 30;
  localparam int WORDS_PER_PHASE = 80;
  localparam longint Q_UNIT = 64'sd65536;
  localparam longint T_CAP = 64'sh0000_003F_FFFF_FFFF;
  localparam longint N_CAP = 64'sd16711680;
  localparam longint WORD_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WORD_LO = -WORD_HI - 1;

  typedef struct packed {
    logic signed [tpii_pkg::XW-1:0] x_first;
    logic signed [tpii_pkg::XW-1:0] x_middle;
    logic signed [tpii_pkg::XW-1:0] y_first;
    logic signed [tpii_pkg::XW-1:0] y_middle;
    logic signed [tpii_pkg::XW-1:0] y_last;
    logic signed [tpii_pkg::XW-1:0] target_y;
  } sample_t;

  typedef struct packed {
    logic signed [tpii_pkg::XW-1:0] x;
    tpii_pkg::status_t              status;
    logic [tpii_pkg::ITW-1:0]       steps;
  } answer_t;

  typedef struct packed {
    logic [tpii_pkg::TOLW-1:0] tol;
    sample_t                   s;
    logic                      known;
    answer_t                   ans;
  } row_t;

  localparam answer_t NO_ANSWER = '0;

  // Directed words. Rows with known set carry an answer that follows directly
  // from the inputs; the rest go through the solver.
  localparam row_t PLAN [21] = '{
    // All zero: flat samples give a zero denominator at once.
    '{17'd66, '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
      1'b1, '{32'sh0, tpii_pkg::STATUS_ZERO_DEN, 8'd0}},
    '{17'd66, '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0005_0000, 32'sh0005_0000,
      32'sh0005_0000, 32'sh0005_0000},
      1'b1, '{32'sh7FFF_FFFF, tpii_pkg::STATUS_ZERO_DEN, 8'd0}},
    '{17'd66, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
      32'sh7FFF_FFFF, 32'sh8000_0000},
      1'b1, '{32'sh8000_0000, tpii_pkg::STATUS_ZERO_DEN, 8'd0}},
    // Target on the middle sample of a straight line: one zero step.
    '{17'd66, '{32'shFFFF_0000, 32'sh0003_0000, 32'sh0, 32'sh0001_0000,
      32'sh0002_0000, 32'sh0001_0000},
      1'b1, '{32'sh0003_0000, tpii_pkg::STATUS_CONVERGED, 8'd1}},
    '{17'd66, '{32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0001_0000,
      32'sh0002_0000, 32'sh0002_0000}, 1'b0, NO_ANSWER},
    // Huge spans push x_result into both saturation limits.
    '{17'd66, '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh0001_0000,
      32'sh0002_0000, 32'sh0002_0000}, 1'b0, NO_ANSWER},
    '{17'd66, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0001_0000,
      32'sh0002_0000, 32'sh0002_0000}, 1'b0, NO_ANSWER},
    // The denominator vanishes on the second step.
    '{17'd66, '{32'sh0, 32'sh0001_0000, 32'shFFFB_0000, 32'shFFFE_0000,
      32'shFFFF_0000, 32'sh0}, 1'b0, NO_ANSWER},
    // Parabola that never reaches the target.
    '{17'd66, '{32'sh0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000,
      32'sh0002_0000, 32'sh0}, 1'b0, NO_ANSWER},
    '{17'd66, '{32'sh0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0,
      32'sh0001_0000, 32'sh0000_4000}, 1'b0, NO_ANSWER},
    // Extreme symmetric ordinates: a and b cancel, so the denominator is zero at once.
    '{17'd66, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
      32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b0, NO_ANSWER},
    '{17'd66, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
      32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b0, NO_ANSWER},
    // Negative products and a falling abscissa exercise floor rounding.
    '{17'd66, '{32'sh0001_8000, 32'sh0001_0000, 32'sh0000_4CCD, 32'shFFFF_8000,
      32'sh0002_1234, 32'sh0000_0001}, 1'b0, NO_ANSWER},
    // With zero tolerance no step is small enough.
    '{17'd0, '{32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0001_0000,
      32'sh0002_0000, 32'sh0002_0000}, 1'b0, NO_ANSWER},
    '{17'd0, '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
      1'b1, '{32'sh0, tpii_pkg::STATUS_ZERO_DEN, 8'd0}},
    // Tolerance above one: the first step always ends the loop.
    '{17'd131071, '{32'sh0, 32'sh0001_0000, 32'shFF9B_0000, 32'shFF9C_0000,
      32'shFF9D_0000, 32'sh0}, 1'b0, NO_ANSWER},
    // A full unit step is not below a tolerance of exactly one.
    '{17'd65536, '{32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0001_0000,
      32'sh0002_0000, 32'sh0002_0000}, 1'b0, NO_ANSWER},
    // Last allowed step is a half step below tolerance: converged, not limit.
    '{17'd32769, '{32'sh0, 32'sh0001_0000, 32'shFFE1_8000, 32'shFFE2_8000,
      32'shFFE3_8000, 32'sh0}, 1'b0, NO_ANSWER},
    '{17'd32769, '{32'sh0, 32'sh0001_0000, 32'shFFD7_0000, 32'shFFD8_0000,
      32'shFFD9_0000, 32'sh0}, 1'b0, NO_ANSWER},
    '{17'd1, '{32'sh0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0,
      32'sh0001_0000, 32'sh0000_4000}, 1'b0, NO_ANSWER},
    '{17'd66, '{32'shFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0000_0100,
      32'sh0000_0200, 32'sh7FFF_0000}, 1'b0, NO_ANSWER}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tpii_pkg::TOLW-1:0] cfg_tolerance = tpii_pkg::TOL_RESET;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [tpii_pkg::XW-1:0] out_x_result;
  logic [1:0] out_status;
  logic [tpii_pkg::ITW-1:0] out_iterations_used;

  logic [tpii_pkg::TOLW-1:0] tol_setting = 17'd66;
  logic calm = 1'b0;
  int mismatches = 0;
  answer_t pending_answers[$];

  always #4 clk = ~clk;

  three_point_inverse_interpolation #(.MAX_ITERATIONS(MAX_STEPS)) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_tolerance       (cfg_tolerance),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_x_first          (in_word.x_first),
    .in_x_middle         (in_word.x_middle),
    .in_y_first          (in_word.y_first),
    .in_y_middle         (in_word.y_middle),
    .in_y_last           (in_word.y_last),
    .in_target_y         (in_word.target_y),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_x_result        (out_x_result),
    .out_status          (out_status),
    .out_iterations_used (out_iterations_used)
  );

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Newton search on the offset n of the quadratic through the three samples.
  function automatic answer_t solve_abscissa(sample_t w, logic [tpii_pkg::TOLW-1:0] tol);
    longint u0, u1, u2, a, b, c, dy, n, t1, t2, num, den, d, xr;
    longint unsigned un, ud, q, mag;
    int steps;
    tpii_pkg::status_t st;
    answer_t r;
    u0 = longint'(w.y_first) - longint'(w.target_y);
    u1 = longint'(w.y_middle) - longint'(w.target_y);
    u2 = longint'(w.y_last) - longint'(w.target_y);
    a = u1 - u0;
    b = u2 - u1;
    c = b - a;
    dy = 2 * u1;
    n = 0;
    steps = 0;
    st = tpii_pkg::STATUS_ITER_LIMIT;
    while (steps < MAX_STEPS) begin
      t1 = clip((c * n) >>> tpii_pkg::QF, T_CAP);
      t2 = clip(a + b + t1, T_CAP);
      num = dy + ((n * t2) >>> tpii_pkg::QF);
      den = t1 + t2;
      if (den == 0) begin
        st = tpii_pkg::STATUS_ZERO_DEN;
        break;
      end
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = (un >= ud) ? Q_UNIT : (un << tpii_pkg::QF) / ud;
      // The step is minus the quotient, limited to one unit either way.
      d = ((num < 0) == (den < 0)) ? -longint'(q) : longint'(q);
      if (num == 0) d = 0;
      n = clip(n + d, N_CAP);
      steps++;
      mag = (d < 0) ? -d : d;
      if (mag < tol) begin
        st = tpii_pkg::STATUS_CONVERGED;
        break;
      end
    end
    xr = longint'(w.x_middle) +
         ((n * (longint'(w.x_middle) - longint'(w.x_first))) >>> tpii_pkg::QF);
    if (xr > WORD_HI) xr = WORD_HI;
    if (xr < WORD_LO) xr = WORD_LO;
    r.x = xr[tpii_pkg::XW-1:0];
    r.status = st;
    r.steps = steps[tpii_pkg::ITW-1:0];
    return r;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic send_word(sample_t w, logic known, answer_t typed);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(known ? typed : solve_abscissa(w, tol_setting));
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Holds off new words until every result is back, then writes the register.
  task automatic set_tolerance(logic [tpii_pkg::TOLW-1:0] v);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_tolerance <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_setting = v;
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 40)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: x=%h status=%0d steps=%0d",
                   out_x_result, out_status, out_iterations_used);
      end else begin
        want = pending_answers.pop_front();
        if (want.x !== out_x_result || want.status !== out_status ||
            want.steps !== out_iterations_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h status=%0d steps=%0d, got x=%h status=%0d steps=%0d",
                     want.x, want.status, want.steps,
                     out_x_result, out_status, out_iterations_used);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [tpii_pkg::TOLW-1:0] phase_tol [7];
    sample_t w;
    int style, base, slope, bend;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].tol != tol_setting) set_tolerance(PLAN[i].tol);
      sender_gap();
      send_word(PLAN[i].s, PLAN[i].known, PLAN[i].ans);
    end

    phase_tol = '{17'd0, 17'd131071, 17'($urandom_range(1, 65536)), 17'd1,
                  17'($urandom), 17'd65536, 17'd66};
    foreach (phase_tol[p]) begin
      set_tolerance(phase_tol[p]);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (p == 6 && k >= WORDS_PER_PHASE / 2) calm = 1'b1;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        style = $urandom_range(0, 99);
        if (style >= 30 && style < 40) begin
          // Flat samples: the denominator is zero from the start.
          w.y_middle = w.y_first;
          w.y_last = w.y_first;
          if ($urandom_range(0, 1) == 1) w.target_y = w.y_first;
        end else if (style >= 40) begin
          // Smooth samples with the target near them, so Newton has a root.
          base = spread(1 << 22);
          slope = spread(1 << 19);
          bend = spread(1 << 17);
          w.y_first = base;
          w.y_middle = base + slope;
          w.y_last = base + 2 * slope + bend;
          w.target_y = base + slope + spread(2 * ((slope < 0) ? -slope : slope) + 65536);
          if ($urandom_range(0, 3) != 0) begin
            w.x_first = spread(1 << 24);
            w.x_middle = w.x_first + spread(1 << 20);
          end
        end
        sender_gap();
        send_word(w, 1'b0, NO_ANSWER);
      end
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
